[src/double_sha256_header_hash_defines.svh]
// Assertion macros for the header hash block.
`ifndef DOUBLE_SHA256_HEADER_HASH_DEFINES_SVH
`define DOUBLE_SHA256_HEADER_HASH_DEFINES_SVH
// Implication checked at every rising clock edge outside reset.
`define DSH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");
// Next-cycle implication checked outside reset.
`define DSH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");
`endif

[src/dsh_pkg.sv]
// ----------------------------------------------------------------------------
// dsh_pkg
// Types, constants and round functions for the double SHA-256 header hash.
// ----------------------------------------------------------------------------
`default_nettype none
package dsh_pkg;
    localparam int unsigned ROUNDS = 64;
    localparam int unsigned RND_W = 6;

    typedef logic [31:0] word_t;
    typedef word_t [7:0] state_t;

    typedef struct packed {
        logic [63:0] hdr_bytes_0_7;
        logic [63:0] hdr_bytes_8_15;
        logic [63:0] hdr_bytes_16_23;
        logic [63:0] hdr_bytes_24_31;
        logic [63:0] hdr_bytes_32_39;
        logic [63:0] hdr_bytes_40_47;
        logic [63:0] hdr_bytes_48_55;
        logic [63:0] hdr_bytes_56_63;
        logic [63:0] hdr_bytes_64_71;
        logic [63:0] hdr_bytes_72_79;
    } hdr_t;

    typedef struct packed {
        logic [63:0] digest_bytes_0_7;
        logic [63:0] digest_bytes_8_15;
        logic [63:0] digest_bytes_16_23;
        logic [63:0] digest_bytes_24_31;
        logic        midstate_hit;
    } dig_t;

    localparam word_t PAD_MARK = 32'h8000_0000;
    localparam word_t LEN_HDR = 32'h0000_0280;
    localparam word_t LEN_DIG = 32'h0000_0100;

    localparam state_t IV = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    function automatic word_t round_k(input logic [RND_W-1:0] i);
        word_t k;
        unique case (i)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic word_t rotr(input word_t x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t sig0(input word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t sig1(input word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic state_t sha_round(input state_t v, input word_t k, input word_t w);
        word_t t1;
        word_t t2;
        state_t r;
        t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k + w;
        t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        r[7] = v[6];
        r[6] = v[5];
        r[5] = v[4];
        r[4] = v[3] + t1;
        r[3] = v[2];
        r[2] = v[1];
        r[1] = v[0];
        r[0] = t1 + t2;
        return r;
    endfunction
endpackage
`default_nettype wire

[src/dsh_if.sv]
// ----------------------------------------------------------------------------
// dsh_hdr_if / dsh_dig_if
// Valid/ready channels for header items and digest items.
// ----------------------------------------------------------------------------
`default_nettype none
interface dsh_hdr_if;
    logic          valid;
    logic          ready;
    dsh_pkg::hdr_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dsh_dig_if;
    logic          valid;
    logic          ready;
    dsh_pkg::dig_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[src/dsh_sched.sv]
// ----------------------------------------------------------------------------
// dsh_sched
// Message schedule held in a 16-entry ring memory, one word per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module dsh_sched (
    input  wire logic           clk,
    input  wire logic           load,
    input  wire logic [3:0]     load_idx,
    input  wire dsh_pkg::word_t load_word,
    input  wire logic [5:0]     rnd,
    output dsh_pkg::word_t      w
);
    // Ring of the last sixteen schedule words; register-file style (four reads).
    dsh_pkg::word_t ring [16];
    dsh_pkg::word_t w_new;

    always_comb
    begin
        if (rnd < 6'd16)
        begin
            w_new = ring[rnd[3:0]];
        end
        else
        begin
            w_new = dsh_pkg::sig1(ring[4'(rnd - 6'd2)]) + ring[4'(rnd - 6'd7)]
                  + dsh_pkg::sig0(ring[4'(rnd - 6'd15)]) + ring[rnd[3:0]];
        end
    end

    assign w = w_new;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ring[load_idx] <= load_word;
        end
        else if (rnd >= 6'd16)
        begin
            ring[rnd[3:0]] <= w_new;
        end
    end
endmodule
`default_nettype wire

[src/double_sha256_header_hash.sv]
// ----------------------------------------------------------------------------
// double_sha256_header_hash
// Double SHA-256 of an 80-byte header with a cached first-block midstate.
// ----------------------------------------------------------------------------
// One header at a time. A header is compared word by word against the cached
// prefix held in a synchronous memory (8 reads; an empty cache leaves at once,
// a mismatch as soon as it is seen). On a hit the midstate is read back from
// its memory, then the tail block and the second hash each load 16 message
// words, run 64 rounds on one shared round unit and add the chaining value.
// On a miss the midstate read is replaced by one more compression of the
// prefix block and a cache write-back. The result sits in an output register;
// the next header is taken only after the result has left.
`default_nettype none
module double_sha256_header_hash (
    input wire logic  clk,
    input wire logic  rst_n,
    dsh_hdr_if.sink   hdr,
    dsh_dig_if.source dig
);
    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_CMP  = 8'b0000_0010,
        S_MRD  = 8'b0000_0100,
        S_LOAD = 8'b0000_1000,
        S_RND  = 8'b0001_0000,
        S_ADD  = 8'b0010_0000,
        S_WB   = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } st_t;

    localparam logic [1:0] B_FIRST = 2'd0;
    localparam logic [1:0] B_TAIL  = 2'd1;
    localparam logic [1:0] B_SEC   = 2'd2;

    st_t               st_reg, st_next;
    dsh_pkg::hdr_t     hdr_reg;
    logic [63:0]       hw [10];
    logic [1:0]        blk_reg;
    logic [4:0]        cnt_reg;
    logic [5:0]        rnd_reg;
    logic              hit_reg, valid_reg;
    dsh_pkg::state_t   h_reg, v_reg;
    logic              cmp_fail;

    // Cache memories with registered reads.
    logic [63:0]       pfx_mem [8];
    dsh_pkg::word_t    mid_mem [8];
    logic [63:0]       pfx_rd_reg;
    dsh_pkg::word_t    mid_rd_reg;
    logic [2:0]        raddr;
    logic              pfx_we;

    dsh_pkg::word_t    load_word, w;
    logic              sched_load;

    assign hw[0] = hdr_reg.hdr_bytes_0_7;
    assign hw[1] = hdr_reg.hdr_bytes_8_15;
    assign hw[2] = hdr_reg.hdr_bytes_16_23;
    assign hw[3] = hdr_reg.hdr_bytes_24_31;
    assign hw[4] = hdr_reg.hdr_bytes_32_39;
    assign hw[5] = hdr_reg.hdr_bytes_40_47;
    assign hw[6] = hdr_reg.hdr_bytes_48_55;
    assign hw[7] = hdr_reg.hdr_bytes_56_63;
    assign hw[8] = hdr_reg.hdr_bytes_64_71;
    assign hw[9] = hdr_reg.hdr_bytes_72_79;

    assign raddr = cnt_reg[2:0];
    assign pfx_we = (st_reg == S_WB);

    always_ff @(posedge clk)
    begin
        pfx_rd_reg <= pfx_mem[raddr];
        mid_rd_reg <= mid_mem[raddr];
        if (pfx_we)
        begin
            pfx_mem[raddr] <= hw[{1'b0, raddr}];
            mid_mem[raddr] <= h_reg[raddr];
        end
    end

    // Drop to a miss on an empty cache or on the first differing prefix word.
    assign cmp_fail = !hit_reg
                    || ((cnt_reg != 5'd0)
                        && (pfx_rd_reg != hw[{1'b0, 3'(cnt_reg - 5'd1)}]));

    // Message word for the current block and load index.
    always_comb
    begin
        load_word = '0;
        unique case (blk_reg)
            B_FIRST:
            begin
                load_word = cnt_reg[0] ? hw[{1'b0, cnt_reg[3:1]}][31:0]
                                       : hw[{1'b0, cnt_reg[3:1]}][63:32];
            end
            B_TAIL:
            begin
                priority if (cnt_reg[3:0] < 4'd4)
                begin
                    load_word = cnt_reg[0] ? hw[{3'd4, cnt_reg[1]}][31:0]
                                           : hw[{3'd4, cnt_reg[1]}][63:32];
                end
                else if (cnt_reg[3:0] == 4'd4)
                begin
                    load_word = dsh_pkg::PAD_MARK;
                end
                else if (cnt_reg[3:0] == 4'd15)
                begin
                    load_word = dsh_pkg::LEN_HDR;
                end
                else
                begin
                    load_word = '0;
                end
            end
            default:
            begin
                priority if (cnt_reg[3:0] < 4'd8)
                begin
                    load_word = h_reg[cnt_reg[2:0]];
                end
                else if (cnt_reg[3:0] == 4'd8)
                begin
                    load_word = dsh_pkg::PAD_MARK;
                end
                else if (cnt_reg[3:0] == 4'd15)
                begin
                    load_word = dsh_pkg::LEN_DIG;
                end
                else
                begin
                    load_word = '0;
                end
            end
        endcase
    end

    assign sched_load = (st_reg == S_LOAD);

    dsh_sched u_sched (
        .clk       (clk),
        .load      (sched_load),
        .load_idx  (cnt_reg[3:0]),
        .load_word (load_word),
        .rnd       (rnd_reg),
        .w         (w)
    );

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            S_IDLE: if (hdr.valid) st_next = S_CMP;
            S_CMP:
            begin
                // cnt runs 0..8: reads issued 0..7, data checked at 1..8
                if (cmp_fail) st_next = S_LOAD;
                else if (cnt_reg == 5'd8) st_next = S_MRD;
            end
            S_MRD: if (cnt_reg == 5'd8) st_next = S_LOAD;
            S_LOAD: if (cnt_reg == 5'd15) st_next = S_RND;
            S_RND: if (rnd_reg == 6'd63) st_next = S_ADD;
            S_ADD:
            begin
                if (blk_reg == B_FIRST) st_next = S_WB;
                else if (blk_reg == B_TAIL) st_next = S_LOAD;
                else st_next = S_OUT;
            end
            S_WB: if (cnt_reg == 5'd7) st_next = S_LOAD;
            S_OUT: if (dig.ready) st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            valid_reg <= 1'b0;
            cnt_reg <= '0;
            rnd_reg <= '0;
            blk_reg <= B_FIRST;
            hit_reg <= 1'b0;
            hdr_reg <= '0;
            h_reg <= '0;
            v_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            unique case (st_reg)
                S_IDLE:
                begin
                    cnt_reg <= '0;
                    hit_reg <= valid_reg;
                    if (hdr.valid) hdr_reg <= hdr.data;
                end
                S_CMP:
                begin
                    if (st_next == S_CMP)
                    begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                    else
                    begin
                        cnt_reg <= '0;
                        if (st_next == S_LOAD)
                        begin
                            // miss: start from IV and hash the prefix
                            hit_reg <= 1'b0;
                            blk_reg <= B_FIRST;
                            h_reg <= dsh_pkg::IV;
                        end
                        else
                        begin
                            blk_reg <= B_TAIL;
                        end
                    end
                end
                S_MRD:
                begin
                    // hit: read the midstate back word by word
                    if (cnt_reg != 5'd0) h_reg[3'(cnt_reg - 5'd1)] <= mid_rd_reg;
                    if (cnt_reg == 5'd8) cnt_reg <= '0;
                    else cnt_reg <= cnt_reg + 5'd1;
                end
                S_LOAD:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    // the second hash chains from IV; digest words go via load
                    v_reg <= (blk_reg == B_SEC) ? dsh_pkg::IV : h_reg;
                    rnd_reg <= '0;
                end
                S_RND:
                begin
                    v_reg <= dsh_pkg::sha_round(v_reg, dsh_pkg::round_k(rnd_reg), w);
                    rnd_reg <= rnd_reg + 6'd1;
                end
                S_ADD:
                begin
                    cnt_reg <= '0;
                    rnd_reg <= '0;
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    if (blk_reg == B_TAIL)
                    begin
                        blk_reg <= B_SEC;
                    end
                    else if (blk_reg == B_FIRST)
                    begin
                        blk_reg <= B_TAIL;
                        valid_reg <= 1'b1;
                    end
                end
                S_WB:
                begin
                    if (cnt_reg == 5'd7) cnt_reg <= '0;
                    else cnt_reg <= cnt_reg + 5'd1;
                end
                S_OUT: ;
                default: ;
            endcase
        end
    end

    // Second hash: add its IV chaining value to the final working state.
    dsh_pkg::state_t res;
    always_comb
    begin
        for (int i = 0; i < 8; i++)
            res[i] = dsh_pkg::IV[i] + v_reg[i];
    end

    logic [255:0] out_reg;
    always_ff @(posedge clk)
    begin
        if (st_reg == S_ADD && blk_reg == B_SEC)
        begin
            out_reg <= {res[0], res[1], res[2], res[3], res[4], res[5], res[6], res[7]};
        end
    end

    assign hdr.ready = (st_reg == S_IDLE);
    assign dig.valid = (st_reg == S_OUT);
    assign dig.data.digest_bytes_0_7 = out_reg[255:192];
    assign dig.data.digest_bytes_8_15 = out_reg[191:128];
    assign dig.data.digest_bytes_16_23 = out_reg[127:64];
    assign dig.data.digest_bytes_24_31 = out_reg[63:0];
    assign dig.data.midstate_hit = hit_reg;
endmodule
`default_nettype wire

[src/dsh_checker.sv]
// ----------------------------------------------------------------------------
// dsh_checker
// Port-level checks on the header hash block.
// ----------------------------------------------------------------------------
`default_nettype none
`include "double_sha256_header_hash_defines.svh"
module dsh_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic out_hit
);
    // one item in flight: no new header while a result waits
    `DSH_ASSERT_IMPL(a_no_overlap, clk, rst_n, out_valid, !in_ready)
    // a result never appears the cycle after acceptance
    `DSH_ASSERT_NEXT(a_latency, clk, rst_n, in_valid && in_ready, !out_valid)
    // a stalled result keeps its hit flag
    `DSH_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, $stable(out_hit))
endmodule

bind double_sha256_header_hash dsh_checker u_dsh_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (hdr.valid),
    .in_ready  (hdr.ready),
    .out_valid (dig.valid),
    .out_ready (dig.ready),
    .out_hit   (dig.data.midstate_hit)
);
`default_nettype wire

[verif/tb_double_sha256_header_hash.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_double_sha256_header_hash
// Sends 80-byte headers through the double SHA-256 block and checks every
// digest and midstate hit flag against an in-bench predictor with its own
// prefix cache. Directed cases cover the empty cache, changed prefixes and
// tail-only changes; random runs mix repeated prefixes with fresh ones.
// ----------------------------------------------------------------------------
module tb_double_sha256_header_hash;
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int unsigned DRAIN_CYCLES = 400;

    logic clk;
    logic rst_n;

    dsh_hdr_if hdr_ch ();
    dsh_dig_if dig_ch ();

    double_sha256_header_hash dut (
        .clk   (clk),
        .rst_n (rst_n),
        .hdr   (hdr_ch.sink),
        .dig   (dig_ch.source)
    );

    // Predictor state
    logic [63:0]     pfx_copy [8];
    dsh_pkg::state_t mid_copy;
    bit              pfx_known;

    dsh_pkg::dig_t   digest_queue [$];
    int unsigned     mismatches;
    int unsigned     cycles;
    bit              no_idle;
    dsh_pkg::hdr_t   last_hdr;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic dsh_pkg::word_t rr(input dsh_pkg::word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic dsh_pkg::state_t compress(input dsh_pkg::state_t hv,
                                                 input dsh_pkg::word_t blk [16]);
        dsh_pkg::word_t  w [64];
        dsh_pkg::word_t  v [8];
        dsh_pkg::word_t  t1;
        dsh_pkg::word_t  t2;
        dsh_pkg::state_t r;
        for (int i = 0; i < 16; i++)
            w[i] = blk[i];
        for (int i = 16; i < 64; i++)
            w[i] = (rr(w[i-2], 17) ^ rr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                 + (rr(w[i-15], 7) ^ rr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
        for (int i = 0; i < 8; i++)
            v[i] = hv[i];
        for (int i = 0; i < 64; i++)
        begin
            t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + dsh_pkg::round_k(i[5:0]) + w[i];
            t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            r[i] = hv[i] + v[i];
        return r;
    endfunction

    function automatic dsh_pkg::dig_t predict_digest(input dsh_pkg::hdr_t h);
        logic [63:0]     wd [10];
        dsh_pkg::word_t  blk [16];
        dsh_pkg::state_t hv;
        bit              hit;
        dsh_pkg::dig_t   d;
        wd = '{h.hdr_bytes_0_7, h.hdr_bytes_8_15, h.hdr_bytes_16_23, h.hdr_bytes_24_31,
               h.hdr_bytes_32_39, h.hdr_bytes_40_47, h.hdr_bytes_48_55,
               h.hdr_bytes_56_63, h.hdr_bytes_64_71, h.hdr_bytes_72_79};
        hit = pfx_known;
        for (int i = 0; i < 8; i++)
            if (pfx_known && pfx_copy[i] != wd[i])
                hit = 1'b0;
        if (!hit)
        begin
            for (int i = 0; i < 8; i++)
            begin
                blk[2*i]   = wd[i][63:32];
                blk[2*i+1] = wd[i][31:0];
                pfx_copy[i] = wd[i];
            end
            mid_copy  = compress(dsh_pkg::IV, blk);
            pfx_known = 1'b1;
        end
        for (int i = 0; i < 16; i++)
            blk[i] = '0;
        blk[0] = wd[8][63:32]; blk[1] = wd[8][31:0];
        blk[2] = wd[9][63:32]; blk[3] = wd[9][31:0];
        blk[4] = dsh_pkg::PAD_MARK;
        blk[15] = dsh_pkg::LEN_HDR;
        hv = compress(mid_copy, blk);
        for (int i = 0; i < 16; i++)
            blk[i] = (i < 8) ? hv[i] : '0;
        blk[8] = dsh_pkg::PAD_MARK;
        blk[15] = dsh_pkg::LEN_DIG;
        hv = compress(dsh_pkg::IV, blk);
        d.digest_bytes_0_7   = {hv[0], hv[1]};
        d.digest_bytes_8_15  = {hv[2], hv[3]};
        d.digest_bytes_16_23 = {hv[4], hv[5]};
        d.digest_bytes_24_31 = {hv[6], hv[7]};
        d.midstate_hit       = hit;
        return d;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic dsh_pkg::hdr_t rand_hdr();
        dsh_pkg::hdr_t h;
        h = {rand64(), rand64(), rand64(), rand64(), rand64(),
             rand64(), rand64(), rand64(), rand64(), rand64()};
        return h;
    endfunction

    function automatic bit idle_now();
        return !no_idle && ($urandom_range(99) < 19);
    endfunction

    // Valid stays high after an item is taken; the next call either idles it
    // or drives the next header in the same step.
    task automatic send_header(input dsh_pkg::hdr_t h);
        while (idle_now())
        begin
            hdr_ch.valid <= 1'b0;
            @(posedge clk);
        end
        hdr_ch.valid <= 1'b1;
        hdr_ch.data  <= h;
        @(posedge clk);
        while (!hdr_ch.ready)
            @(posedge clk);
        digest_queue.push_back(predict_digest(h));
        last_hdr = h;
    endtask

    // Result side: random stalls, compare with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (dig_ch.valid && dig_ch.ready)
            begin
                if (digest_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected digest item %h", dig_ch.data);
                end
                else
                begin
                    dsh_pkg::dig_t want;
                    want = digest_queue.pop_front();
                    if (want !== dig_ch.data)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("digest mismatch: exp %h act %h", want, dig_ch.data);
                    end
                end
            end
            dig_ch.ready <= !idle_now();
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic test_empty_cache();
        dsh_pkg::hdr_t h;
        h = '0;
        send_header(h);
        send_header('1);
        send_header(h);
    endtask

    task automatic test_prefix_change();
        dsh_pkg::hdr_t h;
        h = rand_hdr();
        send_header(h);
        // flip one bit in the first and last prefix words
        h.hdr_bytes_0_7[63] = ~h.hdr_bytes_0_7[63];
        send_header(h);
        h.hdr_bytes_56_63[0] = ~h.hdr_bytes_56_63[0];
        send_header(h);
        h.hdr_bytes_0_7[63] = ~h.hdr_bytes_0_7[63];
        send_header(h);
    endtask

    task automatic test_tail_change();
        dsh_pkg::hdr_t h;
        h = rand_hdr();
        send_header(h);
        for (int i = 0; i < 6; i++)
        begin
            h.hdr_bytes_64_71 = (i == 0) ? '0 : (i == 1) ? '1 : rand64();
            h.hdr_bytes_72_79 = (i == 0) ? '1 : (i == 1) ? '0 : rand64();
            send_header(h);
        end
    endtask

    task automatic test_random(input int unsigned n);
        dsh_pkg::hdr_t h;
        int unsigned sel;
        h = rand_hdr();
        for (int unsigned i = 0; i < n; i++)
        begin
            no_idle = (i >= n / 2) && (i < n / 2 + 150);
            sel = $urandom_range(9);
            if (sel < 5)
            begin
                h.hdr_bytes_64_71 = rand64();
                h.hdr_bytes_72_79 = rand64();
            end
            else if (sel < 7)
            begin
                h = last_hdr;
                h[$urandom_range(639, 128)] ^= 1'b1;
            end
            else
                h = rand_hdr();
            send_header(h);
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        hdr_ch.valid = 1'b0;
        hdr_ch.data = '0;
        dig_ch.ready = 1'b0;
        mismatches = 0;
        cycles = 0;
        no_idle = 1'b0;
        pfx_known = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_cache();
        test_prefix_change();
        test_tail_change();
        test_random(1430);
        hdr_ch.valid <= 1'b0;
        while (digest_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && digest_queue.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
